[src/kea_pkg.sv]
package kea_pkg;

  localparam int unsigned TIME_BITS = 32;
  localparam int unsigned KEY_COUNT = 6;
  localparam int unsigned DIR_BITS  = 4;
  localparam int unsigned ESC_IDX   = 4;
  localparam int unsigned CFG_BITS  = 8;
  localparam int unsigned CFG_IDX_BITS = 2;

  localparam logic [CFG_BITS-1:0] FIRST_DELAY_RST = 8'd12;
  localparam logic [CFG_BITS-1:0] PERIOD_RST      = 8'd5;
  localparam logic [CFG_BITS-1:0] ESC_DELAY_RST   = 8'd4;

  typedef enum logic [1:0] {
    KIND_SAMPLE   = 2'd0,
    KIND_SUPPRESS = 2'd1,
    KIND_CANCEL   = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FIRST_DELAY = 2'd0,
    CFG_PERIOD      = 2'd1,
    CFG_ESC_DELAY   = 2'd2
  } cfg_idx_e;

  // one transfer moving from the input register into the result register
  typedef struct packed {
    logic  en;
    kind_e kind;
  } step_t;

  // due test on the sign of the wrapping difference
  function automatic logic reached(input logic [TIME_BITS-1:0] now,
                                   input logic [TIME_BITS-1:0] due);
    logic [TIME_BITS-1:0] diff;
    diff = now - due;
    return ~diff[TIME_BITS-1];
  endfunction

  function automatic logic [TIME_BITS-1:0] add_ticks(input logic [TIME_BITS-1:0] now,
                                                     input logic [CFG_BITS-1:0] ticks);
    return now + {{(TIME_BITS-CFG_BITS){1'b0}}, ticks};
  endfunction

endpackage

[src/kea_edge.sv]
module kea_edge (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  kea_pkg::step_t                      step_i,
  input  logic [kea_pkg::KEY_COUNT-1:0]       keys_i,
  input  logic [kea_pkg::TIME_BITS-1:0]       now_i,
  input  logic                                touch_held_i,
  input  logic [kea_pkg::CFG_BITS-1:0]        escape_delay_i,
  output logic [kea_pkg::KEY_COUNT-1:0]       pressed_o
);

  logic [kea_pkg::KEY_COUNT-1:0] last_q, last_d;
  logic                          masked_q, masked_d;
  logic                          waiting_q, waiting_d;
  logic [kea_pkg::TIME_BITS-1:0] esc_time_q, esc_time_d;

  always_comb begin
    logic [kea_pkg::KEY_COUNT-1:0] cur;
    logic [kea_pkg::KEY_COUNT-1:0] p;
    cur        = keys_i;
    p          = '0;
    last_d     = last_q;
    masked_d   = masked_q;
    waiting_d  = waiting_q;
    esc_time_d = esc_time_q;
    case (step_i.kind)
      kea_pkg::KIND_SAMPLE: begin
        if (masked_q) begin
          if (!touch_held_i && !cur[kea_pkg::ESC_IDX]) begin
            masked_d = 1'b0;
          end
          cur[kea_pkg::ESC_IDX] = 1'b0;
          waiting_d = 1'b0;
        end
        p      = cur & ~last_q;
        last_d = cur;
        if (p[kea_pkg::ESC_IDX]) begin
          waiting_d  = 1'b1;
          esc_time_d = kea_pkg::add_ticks(now_i, escape_delay_i);
        end
        p[kea_pkg::ESC_IDX] = 1'b0;
        // delayed escape report, zero delay reports in the same sample
        if (waiting_d && kea_pkg::reached(now_i, esc_time_d)) begin
          waiting_d = 1'b0;
          p[kea_pkg::ESC_IDX] = 1'b1;
        end
      end
      kea_pkg::KIND_SUPPRESS: begin
        masked_d  = 1'b1;
        waiting_d = 1'b0;
        last_d[kea_pkg::ESC_IDX] = 1'b0;
      end
      default: begin
      end
    endcase
    pressed_o = p;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q     <= '0;
      masked_q   <= 1'b0;
      waiting_q  <= 1'b0;
      esc_time_q <= '0;
    end else if (step_i.en) begin
      last_q     <= last_d;
      masked_q   <= masked_d;
      waiting_q  <= waiting_d;
      esc_time_q <= esc_time_d;
    end
  end

`ifndef SYNTHESIS
  // while masked, escape never counts as a held level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    masked_q |-> !last_q[kea_pkg::ESC_IDX])
    else $error("escape level stored while masked");

  // a masked escape cannot be pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    masked_q |-> !waiting_q)
    else $error("escape pending while masked");
`endif

endmodule

[src/kea_repeat.sv]
module kea_repeat (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  kea_pkg::step_t                      step_i,
  input  logic [kea_pkg::DIR_BITS-1:0]        dirs_i,
  input  logic [kea_pkg::TIME_BITS-1:0]       now_i,
  input  logic                                repeat_enable_i,
  input  logic [kea_pkg::CFG_BITS-1:0]        first_delay_i,
  input  logic [kea_pkg::CFG_BITS-1:0]        period_i,
  output logic [kea_pkg::DIR_BITS-1:0]        repeat_o
);

  logic [kea_pkg::DIR_BITS-1:0]  dir_q, dir_d;
  logic [kea_pkg::TIME_BITS-1:0] time_q, time_d;
  logic                          single;

  // exactly one direction held
  assign single = (dirs_i != '0) && ((dirs_i & (dirs_i - 1'b1)) == '0);

  always_comb begin
    dir_d    = dir_q;
    time_d   = time_q;
    repeat_o = '0;
    case (step_i.kind)
      kea_pkg::KIND_SAMPLE: begin
        if (!repeat_enable_i || !single) begin
          dir_d = '0;
        end else if (dirs_i != dir_q) begin
          dir_d  = dirs_i;
          time_d = kea_pkg::add_ticks(now_i, first_delay_i);
        end else if (kea_pkg::reached(now_i, time_q)) begin
          time_d   = kea_pkg::add_ticks(now_i, period_i);
          repeat_o = dirs_i;
        end
      end
      kea_pkg::KIND_CANCEL: begin
        dir_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q  <= '0;
      time_q <= '0;
    end else if (step_i.en) begin
      dir_q  <= dir_d;
      time_q <= time_d;
    end
  end

`ifndef SYNTHESIS
  // the tracked direction is at most one key
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(dir_q))
    else $error("repeat tracks several directions");
`endif

endmodule

[src/keypad_edge_and_autorepeat_core.sv]
// Keypad conditioning core. Each key sample returns one pressed mask: the
// rising edges of the six keys (bits 0-3 directions, bit 4 escape, bit 5
// confirm), with escape held back by escape_delay ticks, plus an auto-repeat
// bit for a single held direction after repeat_first_delay and then every
// repeat_period ticks. Touch suppress (kind 1) and cancel (kind 2) transfers
// also return one result, always zero. Every timestamp test uses the sign
// of the wrapping difference at TIME_BITS bits. Throughput is one transfer
// per cycle while the result channel does not stall. Each transfer passes
// through the input register, then the edge and repeat logic updates its
// state and loads the result register in one pass. The configuration port
// writes at once and should only be used while no transfer is in flight.
module keypad_edge_and_autorepeat_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [kea_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [kea_pkg::CFG_BITS-1:0]       cfg_data_i,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         kind_i,
  input  logic [kea_pkg::TIME_BITS-1:0]      now_i,
  input  logic [kea_pkg::KEY_COUNT-1:0]      keys_i,
  input  logic                               touch_held_i,
  input  logic                               repeat_enable_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [kea_pkg::KEY_COUNT-1:0]      pressed_o
);

  // configuration registers
  logic [kea_pkg::CFG_BITS-1:0] first_delay_q, period_q, esc_delay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_delay_q <= kea_pkg::FIRST_DELAY_RST;
      period_q      <= kea_pkg::PERIOD_RST;
      esc_delay_q   <= kea_pkg::ESC_DELAY_RST;
    end else if (cfg_we_i) begin
      case (kea_pkg::cfg_idx_e'(cfg_idx_i))
        kea_pkg::CFG_FIRST_DELAY: first_delay_q <= cfg_data_i;
        kea_pkg::CFG_PERIOD:      period_q      <= cfg_data_i;
        kea_pkg::CFG_ESC_DELAY:   esc_delay_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // input register
  logic                          s0_valid_q;
  kea_pkg::kind_e                kind_q;
  logic [kea_pkg::TIME_BITS-1:0] now_q;
  logic [kea_pkg::KEY_COUNT-1:0] keys_q;
  logic                          touch_q;
  logic                          rep_en_q;

  logic                          out_valid_q;
  logic [kea_pkg::KEY_COUNT-1:0] pressed_q, pressed_d;
  logic                          res_free;
  logic                          advance;
  logic                          in_xfer;
  kea_pkg::step_t                step;

  // the result register frees up in the same cycle its transfer completes
  assign res_free   = !out_valid_q || out_ready_i;
  assign advance    = s0_valid_q && res_free;
  assign in_ready_o = !s0_valid_q || res_free;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign step.en   = advance;
  assign step.kind = kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      kind_q   <= kea_pkg::kind_e'(kind_i);
      now_q    <= now_i;
      keys_q   <= keys_i;
      touch_q  <= touch_held_i;
      rep_en_q <= repeat_enable_i;
    end
  end

  // edge detection and delayed escape
  logic [kea_pkg::KEY_COUNT-1:0] edge_pressed;

  kea_edge u_edge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .keys_i         (keys_q),
    .now_i          (now_q),
    .touch_held_i   (touch_q),
    .escape_delay_i (esc_delay_q),
    .pressed_o      (edge_pressed)
  );

  // direction auto-repeat
  logic [kea_pkg::DIR_BITS-1:0] rep_dirs;

  kea_repeat u_repeat (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .dirs_i          (keys_q[kea_pkg::DIR_BITS-1:0]),
    .now_i           (now_q),
    .repeat_enable_i (rep_en_q),
    .first_delay_i   (first_delay_q),
    .period_i        (period_q),
    .repeat_o        (rep_dirs)
  );

  // both sub-blocks drive zero for event kinds
  assign pressed_d = edge_pressed
                   | {{(kea_pkg::KEY_COUNT-kea_pkg::DIR_BITS){1'b0}}, rep_dirs};

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_free) begin
      out_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      pressed_q <= pressed_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pressed_o   = pressed_q;

`ifndef SYNTHESIS
  // suppress and cancel transfers always yield an empty mask
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && kind_q != kea_pkg::KIND_SAMPLE) |=> (out_valid_o && pressed_o == '0))
    else $error("event transfer produced key presses");

  // a full input register with a stalled result blocks new transfers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s0_valid_q && !advance) |-> !in_ready_o)
    else $error("input accepted while pipeline stalled");
`endif

endmodule
